// ----- hw/rtl/plu_pkg.sv -----
// Shared types and constants for the particle life update block.
// No dependencies; used by particle_life_update and plu_div.
`default_nettype none

package plu_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned QUO_W       = 16;
    localparam int unsigned DIV_STAGES  = 8;
    localparam int unsigned DIV_STEPS   = QUO_W / DIV_STAGES;
    localparam int unsigned IN_DATA_W   = 288;
    localparam int unsigned OUT_DATA_W  = 176;
    localparam int unsigned ONE_Q16     = 65536;

    // How the blend factor is chosen.
    typedef enum logic [1:0] {
        T_DIV  = 2'd0,
        T_ZERO = 2'd1,
        T_ONE  = 2'd2
    } t_tsel;

    typedef enum logic [1:0] {
        REG_START_COLOR = 2'd0,
        REG_END_COLOR   = 2'd1,
        REG_START_SIZE  = 2'd2,
        REG_END_SIZE    = 2'd3
    } t_reg_idx;

    // First stage: life update and motion products.
    typedef struct packed {
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic [31:0]        angle;
        logic signed [63:0] prod_x;
        logic signed [63:0] prod_y;
        logic signed [63:0] prod_a;
        logic [31:0]        life;
        logic [31:0]        full;
        logic               live;
    } t_s1;

    // Payload that travels beside the divider.
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] angle;
        logic [31:0] life;
        logic        live;
        t_tsel       tsel;
    } t_side;

endpackage

`default_nettype wire

// ----- hw/rtl/plu_div.sv -----
// Pipelined restoring divider for the life ratio, two quotient bits per stage.
// Depends on plu_pkg; stage enables come from the top level's stall chain.
`default_nettype none

module plu_div (
    input  wire logic                           i_clk,
    input  wire logic [plu_pkg::DIV_STAGES-1:0] i_en,
    input  wire logic [31:0]                    i_rem,
    input  wire logic [31:0]                    i_den,
    output logic      [plu_pkg::QUO_W-1:0]      o_quo
);

    logic [31:0]               r_rem [plu_pkg::DIV_STAGES];
    logic [31:0]               r_den [plu_pkg::DIV_STAGES];
    logic [plu_pkg::QUO_W-1:0] r_quo [plu_pkg::DIV_STAGES];
    logic [31:0]               n_rem [plu_pkg::DIV_STAGES];
    logic [plu_pkg::QUO_W-1:0] n_quo [plu_pkg::DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < plu_pkg::DIV_STAGES; j++) begin : g_stage
            logic [31:0]               w_rem_in;
            logic [31:0]               w_den_in;
            logic [plu_pkg::QUO_W-1:0] w_quo_in;

            if (j == 0) begin : g_first
                assign w_rem_in = i_rem;
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[j-1];
                assign w_den_in = r_den[j-1];
                assign w_quo_in = r_quo[j-1];
            end

            // Shift in a zero numerator bit, subtract when it fits.
            always_comb begin
                logic [32:0] rem2;
                n_rem[j] = w_rem_in;
                n_quo[j] = w_quo_in;
                for (int k = 0; k < plu_pkg::DIV_STEPS; k++) begin
                    rem2 = {n_rem[j], 1'b0};
                    if (rem2 >= {1'b0, w_den_in}) begin
                        n_rem[j] = 32'(rem2 - {1'b0, w_den_in});
                        n_quo[j] = {n_quo[j][plu_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        n_rem[j] = rem2[31:0];
                        n_quo[j] = {n_quo[j][plu_pkg::QUO_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= n_rem[j];
                    r_den[j] <= w_den_in;
                    r_quo[j] <= n_quo[j];
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[plu_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- hw/rtl/particle_life_update.sv -----
// Top level of the particle life update pipeline.
// Depends on plu_pkg and plu_div.
`default_nettype none

// One particle record enters per word on the slave stream and one updated
// record leaves per word on the master stream, in order. The pipeline is
// eleven register stages deep: life update and motion products, motion
// add with saturation beside the first of eight divider stages that form the
// sixteen-bit life ratio two bits at a time, blend products, and the final
// blend sum that sits in the output register. Sustained rate is one word per
// cycle while words arrive and the master stream is ready. Each stage holds
// its word while the one after it is full and stalled, so a bubble anywhere
// is filled even while the output waits. Colors and sizes must be written
// through the plain register port while the stream is idle, which the block
// does not enforce; they are read straight into the blend stage.
module particle_life_update (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave stream
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // step_time, pos_x, pos_y, vel_x, vel_y, remaining_life, full_life,
    // angle, spin_rate (32 bits each, from bit 0 up)
    input  wire logic [287:0] i_s_axis_tdata,
    // is_alive
    input  wire logic         i_s_axis_tuser,
    // master stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // out_pos_x, out_pos_y, out_angle, out_life, out_color (32 each),
    // out_size (16), from bit 0 up
    output logic      [175:0] o_m_axis_tdata,
    // out_alive
    output logic              o_m_axis_tuser,
    // register port
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [31:0]  i_cfg_wdata
);

    localparam int unsigned NST = plu_pkg::DIV_STAGES + 3;

    // Stage map: 0 life/products, 1..8 motion sum and divider,
    // NST-2 blend products, NST-1 output.
    logic [NST-1:0] r_v;
    logic [NST:0]   w_en;

    always_comb begin
        w_en[NST] = i_m_axis_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Configuration registers.
    logic [31:0] r_start_color;
    logic [31:0] r_end_color;
    logic [15:0] r_start_size;
    logic [15:0] r_end_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color <= 32'hFFFF_FFFF;
            r_end_color   <= 32'h0;
            r_start_size  <= 16'd2048;
            r_end_size    <= 16'd512;
        end else if (i_cfg_we) begin
            case (plu_pkg::t_reg_idx'(i_cfg_addr))
                plu_pkg::REG_START_COLOR: r_start_color <= i_cfg_wdata;
                plu_pkg::REG_END_COLOR:   r_end_color   <= i_cfg_wdata;
                plu_pkg::REG_START_SIZE:  r_start_size  <= i_cfg_wdata[15:0];
                plu_pkg::REG_END_SIZE:    r_end_size    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Stage 0: drop life by the step, form velocity and spin rate times step.
    logic [31:0] w_dt, w_life, w_full;
    logic        w_alive, w_dies;
    assign w_dt    = i_s_axis_tdata[31:0];
    assign w_life  = i_s_axis_tdata[191:160];
    assign w_full  = i_s_axis_tdata[223:192];
    assign w_alive = i_s_axis_tuser;
    assign w_dies  = (w_life <= w_dt);

    plu_pkg::t_s1 r_s1, n_s1;

    always_comb begin
        n_s1.pos_x  = i_s_axis_tdata[63:32];
        n_s1.pos_y  = i_s_axis_tdata[95:64];
        n_s1.angle  = i_s_axis_tdata[255:224];
        n_s1.prod_x = $signed(i_s_axis_tdata[127:96]) * $signed({1'b0, w_dt});
        n_s1.prod_y = $signed(i_s_axis_tdata[159:128]) * $signed({1'b0, w_dt});
        n_s1.prod_a = $signed(i_s_axis_tdata[287:256]) * $signed({1'b0, w_dt});
        n_s1.full   = w_full;
        n_s1.live   = w_alive && !w_dies;
        if (!w_alive) begin
            n_s1.life = w_life;
        end else if (w_dies) begin
            n_s1.life = '0;
        end else begin
            n_s1.life = w_life - w_dt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1 <= n_s1;
        end
    end

    // Add the floored product to a position and clamp to the signed range.
    function automatic logic [31:0] sat_add(input logic [31:0] pos,
                                            input logic signed [63:0] prod);
        logic signed [48:0] sum;
        sum = $signed({{17{pos[31]}}, pos}) + $signed({prod[63], prod[63:16]});
        if (sum[48:31] == '0 || sum[48:31] == '1) begin
            return sum[31:0];
        end else if (sum[48]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    // Stage 1: motion result and blend factor selection; divider starts here.
    plu_pkg::t_side r_side [plu_pkg::DIV_STAGES];
    plu_pkg::t_side n_side;

    always_comb begin
        n_side.live  = r_s1.live;
        n_side.life  = r_s1.life;
        n_side.pos_x = r_s1.live ? sat_add(r_s1.pos_x, r_s1.prod_x) : r_s1.pos_x;
        n_side.pos_y = r_s1.live ? sat_add(r_s1.pos_y, r_s1.prod_y) : r_s1.pos_y;
        n_side.angle = r_s1.live ? sat_add(r_s1.angle, r_s1.prod_a) : r_s1.angle;
        if (r_s1.full == '0) begin
            n_side.tsel = plu_pkg::T_ONE;
        end else if (r_s1.life >= r_s1.full) begin
            n_side.tsel = plu_pkg::T_ZERO;
        end else begin
            n_side.tsel = plu_pkg::T_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_side[0] <= n_side;
        end
        for (int j = 1; j < plu_pkg::DIV_STAGES; j++) begin
            if (w_en[j+1]) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    logic [plu_pkg::QUO_W-1:0] w_quo;

    plu_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en[plu_pkg::DIV_STAGES:1]),
        .i_rem (r_s1.life),
        .i_den (r_s1.full),
        .o_quo (w_quo)
    );

    // Blend product stage.
    logic [16:0] w_t, w_tc;
    plu_pkg::t_side w_last;
    assign w_last = r_side[plu_pkg::DIV_STAGES-1];

    always_comb begin
        case (w_last.tsel)
            plu_pkg::T_ONE:  w_t = 17'(plu_pkg::ONE_Q16);
            plu_pkg::T_ZERO: w_t = '0;
            default:         w_t = 17'(plu_pkg::ONE_Q16) - {1'b0, w_quo};
        endcase
        w_tc = 17'(plu_pkg::ONE_Q16) - w_t;
    end

    logic [24:0]    r_cs [4];
    logic [24:0]    r_ce [4];
    logic [32:0]    r_ss, r_se;
    plu_pkg::t_side r_bl;

    always_ff @(posedge i_clk) begin
        if (w_en[NST-2]) begin
            for (int c = 0; c < 4; c++) begin
                r_cs[c] <= r_start_color[c*8 +: 8] * w_tc;
                r_ce[c] <= r_end_color[c*8 +: 8] * w_t;
            end
            r_ss <= r_start_size * w_tc;
            r_se <= r_end_size * w_t;
            r_bl <= w_last;
        end
    end

    // Output stage: sum, truncate, zero for dead words.
    logic [31:0] n_color;
    logic [15:0] n_size;

    always_comb begin
        logic [25:0] csum;
        logic [33:0] ssum;
        n_color = '0;
        for (int c = 0; c < 4; c++) begin
            csum = {1'b0, r_cs[c]} + {1'b0, r_ce[c]};
            n_color[c*8 +: 8] = csum[23:16];
        end
        ssum   = {1'b0, r_ss} + {1'b0, r_se};
        n_size = ssum[31:16];
        if (!r_bl.live) begin
            n_color = '0;
            n_size  = '0;
        end
    end

    logic [175:0] r_odata;
    logic         r_oalive;

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            r_odata  <= {n_size, n_color, r_bl.life, r_bl.angle, r_bl.pos_y, r_bl.pos_x};
            r_oalive <= r_bl.live;
        end
    end

    assign o_m_axis_tvalid = r_v[NST-1];
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_oalive;

endmodule

`default_nettype wire

// ----- hw/rtl/plu_checker.sv -----
// Port-level checks for particle_life_update, attached by bind.
// No package dependency; sees the top level's ports only.
`default_nettype none

module plu_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [175:0] o_m_axis_tdata,
    input wire logic         o_m_axis_tuser
);

    // A stalled output word stays valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    // An empty output stage never blocks the input.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty pipeline");

    // Dead words carry no color or size.
    a_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[175:128] == '0)
        else $error("dead word with color or size");

    // A live word has life left.
    a_life: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[127:96] != '0)
        else $error("live word with zero life");

endmodule

bind particle_life_update plu_checker u_plu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
